[hdl/fpa_pkg.sv]
// Shared types and codes for the fixed-point ALU.
// Holds the request and response beat structs and the operation codes.
// Depends on nothing.
`default_nettype none

package fpa_pkg;

	// Width of every operand and result field on the ports
	localparam int FIELD_BITS = 32;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_MIN      = 4'd4,
		OP_MAX      = 4'd5,
		OP_INC      = 4'd6,
		OP_DEC      = 4'd7,
		OP_FROM_INT = 4'd8,
		OP_TO_INT   = 4'd9
	} fpa_op_t;

	typedef struct packed {
		logic [3:0]                   action;
		logic signed [FIELD_BITS-1:0] operand_a;
		logic signed [FIELD_BITS-1:0] operand_b;
	} fpa_req_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] result;
		logic                         a_less_b;
		logic                         a_equal_b;
		logic                         a_greater_b;
		logic                         overflow;
		logic                         div_by_zero;
	} fpa_rsp_t;

endpackage

`default_nettype wire

[hdl/fpa_div_cell.sv]
// One restoring-division step of the divider chain.
// Takes one numerator bit into the partial remainder and emits one quotient bit.
// Standalone; no package needed.
`default_nettype none

module fpa_div_cell #(
	parameter int REM_BITS = 32,
	parameter int NQ_BITS  = 40
) (
	input  logic                clk,
	input  logic                en,
	input  logic [REM_BITS-1:0] rem_i,
	input  logic [NQ_BITS-1:0]  nq_i,
	input  logic [REM_BITS-1:0] den_i,
	output logic [REM_BITS-1:0] rem_o,
	output logic [NQ_BITS-1:0]  nq_o,
	output logic [REM_BITS-1:0] den_o
);

	logic [REM_BITS:0]   trial;
	logic                fits;
	logic [REM_BITS-1:0] rem_q;
	logic [NQ_BITS-1:0]  nq_q;
	logic [REM_BITS-1:0] den_q;

	// Shift in the next numerator bit and try the subtract
	assign trial = {rem_i, nq_i[NQ_BITS-1]};
	assign fits  = trial >= {1'b0, den_i};

	// Advance remainder, numerator/quotient word and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? REM_BITS'(trial - {1'b0, den_i}) : trial[REM_BITS-1:0];
			nq_q  <= {nq_i[NQ_BITS-2:0], fits};
			den_q <= den_i;
		end
	end

	assign rem_o = rem_q;
	assign nq_o  = nq_q;
	assign den_o = den_q;

endmodule

`default_nettype wire

[hdl/fixed_point_alu_top.sv]
// Top level of the signed fixed-point ALU: decode stage, divider cell chain,
// rounding and saturation stages. Uses fpa_pkg and fpa_div_cell.
`default_nettype none

// Signed fixed-point ALU on raw two's-complement words (Q24.8 by default).
// Takes one request beat per cycle while req_stall is low and returns one
// response beat per request, in order. Every operation travels through a
// divider chain of min(WORD_BITS,32) + FRAC_BITS restoring-division cells,
// one quotient bit per cell, to keep results in order. A stall on the
// response side while a response beat waits holds the whole pipeline and
// is passed to req_stall in the same cycle.
// Multiply and divide round half away from zero, results outside the word
// range saturate and raise overflow, and divide by zero returns the limit
// that matches the sign of operand_a with div_by_zero set.
module fixed_point_alu_top import fpa_pkg::*; #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  fpa_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output fpa_rsp_t rsp
);

	// Operand bits, divider steps and the width that holds any raw result
	localparam int OB = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam int NQ = OB + FRAC_BITS;
	localparam int QB = NQ + 1;
	localparam int PB = 2 * OB;
	localparam int CW = ((WORD_BITS > PB) ? WORD_BITS : PB) + 1;

	localparam logic [CW-1:0] LIM_POS = (CW'(1) << (WORD_BITS - 1)) - CW'(1);
	localparam logic [CW-1:0] LIM_NEG = CW'(1) << (WORD_BITS - 1);
	localparam logic [CW-1:0] RND_UP  = CW'(1) << (FRAC_BITS - 1);
	localparam logic [CW-1:0] RND_DN  = RND_UP - CW'(1);
	localparam logic [WORD_BITS-1:0] WMAX_W = LIM_POS[WORD_BITS-1:0];
	localparam logic [WORD_BITS-1:0] WMIN_W = LIM_NEG[WORD_BITS-1:0];

	typedef struct packed {
		logic                 is_div;
		logic                 neg;
		logic                 dz;
		logic                 a_neg;
		logic                 lt;
		logic                 eq;
		logic                 gt;
		logic                 ovf;
		logic [WORD_BITS-1:0] value;
	} side_t;

	logic en;

	// Decode stage signals
	logic signed [OB-1:0] a_x;
	logic signed [OB-1:0] b_x;
	logic                 lt_d;
	logic                 eq_d;
	logic                 gt_d;
	logic signed [CW-1:0] rv_d;
	logic signed [PB-1:0] prod_d;
	logic [OB-1:0]        a_mag;
	logic [OB-1:0]        b_mag;

	logic                 vld_s1;
	fpa_op_t              op_s1;
	logic signed [CW-1:0] rv_s1;
	logic signed [PB-1:0] prod_s1;
	logic                 lt_s1;
	logic                 eq_s1;
	logic                 gt_s1;
	logic                 neg_s1;
	logic                 dz_s1;
	logic                 aneg_s1;
	logic [NQ-1:0]        num_s1;
	logic [OB-1:0]        den_s1;

	// Side path signals
	logic signed [CW-1:0] mul_sum;
	logic signed [CW-1:0] pre_sat;
	logic                 sat_hi;
	logic                 sat_lo;
	side_t                side_d;
	side_t                side_q [0:NQ];
	logic [NQ:0]          vld_q;

	// Divider chain wires
	logic [OB-1:0] rem_w [0:NQ];
	logic [NQ-1:0] nq_w  [0:NQ];
	logic [OB-1:0] den_w [0:NQ];

	// Rounding and output stage signals
	logic                 rnd_bit;
	logic [QB-1:0]        quo_rnd_q;
	logic [CW-1:0]        quo_ext;
	logic [WORD_BITS-1:0] quo_w;
	logic [WORD_BITS-1:0] quo_signed;
	logic                 div_ovf;
	side_t                side_last;
	logic [WORD_BITS-1:0] res_w;
	logic                 ovf_w;
	fpa_rsp_t             rsp_d;
	fpa_rsp_t             rsp_q;
	logic                 rsp_valid_q;

	// Hold everything while a response beat waits on a stall
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = rsp_valid_q && rsp_stall;

	// Operands come from the low word bits, sign-extended
	assign a_x  = $signed(req.operand_a[OB-1:0]);
	assign b_x  = $signed(req.operand_b[OB-1:0]);
	assign lt_d = a_x < b_x;
	assign eq_d = a_x == b_x;
	assign gt_d = a_x > b_x;

	// Unsaturated result of the operations other than multiply and divide
	always_comb begin
		case (fpa_op_t'(req.action))
			OP_ADD:      rv_d = CW'(a_x) + CW'(b_x);
			OP_SUB:      rv_d = CW'(a_x) - CW'(b_x);
			OP_MIN:      rv_d = lt_d ? CW'(a_x) : CW'(b_x);
			OP_MAX:      rv_d = gt_d ? CW'(a_x) : CW'(b_x);
			OP_INC:      rv_d = CW'(a_x) + CW'(1);
			OP_DEC:      rv_d = CW'(a_x) - CW'(1);
			OP_FROM_INT: rv_d = CW'(a_x) <<< FRAC_BITS;
			OP_TO_INT:   rv_d = CW'(a_x >>> FRAC_BITS);
			default:     rv_d = '0;
		endcase
	end

	assign prod_d = PB'(a_x) * PB'(b_x);
	assign a_mag  = a_x[OB-1] ? OB'(-a_x) : OB'(a_x);
	assign b_mag  = b_x[OB-1] ? OB'(-b_x) : OB'(b_x);

	// Decode stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
		end
	end

	// Decode stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= fpa_op_t'(req.action);
			rv_s1   <= rv_d;
			prod_s1 <= prod_d;
			lt_s1   <= lt_d;
			eq_s1   <= eq_d;
			gt_s1   <= gt_d;
			neg_s1  <= a_x[OB-1] ^ b_x[OB-1];
			dz_s1   <= b_x == '0;
			aneg_s1 <= a_x[OB-1];
			num_s1  <= {a_mag, {FRAC_BITS{1'b0}}};
			den_s1  <= b_mag;
		end
	end

	// Round the product half away from zero, then saturate
	assign mul_sum = CW'(prod_s1) + $signed(prod_s1[PB-1] ? RND_DN : RND_UP);
	assign pre_sat = (op_s1 == OP_MUL) ? (mul_sum >>> FRAC_BITS) : rv_s1;
	assign sat_hi  = pre_sat > $signed(LIM_POS);
	assign sat_lo  = pre_sat < $signed(~LIM_POS);

	always_comb begin
		side_d.is_div = op_s1 == OP_DIV;
		side_d.neg    = neg_s1;
		side_d.dz     = dz_s1;
		side_d.a_neg  = aneg_s1;
		side_d.lt     = lt_s1;
		side_d.eq     = eq_s1;
		side_d.gt     = gt_s1;
		side_d.ovf    = sat_hi || sat_lo;
		if (sat_hi) begin
			side_d.value = WMAX_W;
		end else if (sat_lo) begin
			side_d.value = WMIN_W;
		end else begin
			side_d.value = pre_sat[WORD_BITS-1:0];
		end
	end

	// Side path valid runs beside the divider chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NQ-1:0], vld_s1};
		end
	end

	// Side path payload advances with the cells
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_d;
			for (int k = 1; k <= NQ; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Divider chain, one quotient bit per cell
	assign rem_w[0] = '0;
	assign nq_w[0]  = num_s1;
	assign den_w[0] = den_s1;

	for (genvar g = 0; g < NQ; g++) begin : g_cell
		fpa_div_cell #(
			.REM_BITS(OB),
			.NQ_BITS (NQ)
		) u_cell (
			.clk  (clk),
			.en   (en),
			.rem_i(rem_w[g]),
			.nq_i (nq_w[g]),
			.den_i(den_w[g]),
			.rem_o(rem_w[g+1]),
			.nq_o (nq_w[g+1]),
			.den_o(den_w[g+1])
		);
	end

	// Round the quotient up when twice the remainder reaches the divisor
	assign rnd_bit = {rem_w[NQ], 1'b0} >= {1'b0, den_w[NQ]};

	always_ff @(posedge clk) begin
		if (en) begin
			quo_rnd_q <= {1'b0, nq_w[NQ]} + QB'(rnd_bit);
		end
	end

	// Apply sign and saturate the quotient, then merge with the side path
	assign side_last  = side_q[NQ];
	assign quo_ext    = CW'(quo_rnd_q);
	assign quo_w      = WORD_BITS'(quo_ext);
	assign quo_signed = side_last.neg ? (~quo_w + WORD_BITS'(1)) : quo_w;
	assign div_ovf    = side_last.neg ? (quo_ext > LIM_NEG) : (quo_ext > LIM_POS);

	always_comb begin
		if (!side_last.is_div) begin
			res_w = side_last.value;
			ovf_w = side_last.ovf;
		end else if (side_last.dz) begin
			res_w = side_last.a_neg ? WMIN_W : WMAX_W;
			ovf_w = 1'b0;
		end else if (div_ovf) begin
			res_w = side_last.neg ? WMIN_W : WMAX_W;
			ovf_w = 1'b1;
		end else begin
			res_w = quo_signed;
			ovf_w = 1'b0;
		end
		rsp_d.result      = FIELD_BITS'($signed(res_w));
		rsp_d.a_less_b    = side_last.lt;
		rsp_d.a_equal_b   = side_last.eq;
		rsp_d.a_greater_b = side_last.gt;
		rsp_d.overflow    = ovf_w;
		rsp_d.div_by_zero = side_last.is_div && side_last.dz;
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= vld_q[NQ];
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for fixed_point_alu_top: directed corner beats, then random
// beats with random idling on both sides and one long response hold-off.
// Depends on fpa_pkg and the fixed_point_alu_top RTL.
`timescale 1ns / 100ps

module tb;
	import fpa_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int WORD_BITS = 32;
	localparam int IN_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam longint WORD_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;

	localparam logic [FIELD_BITS-1:0] FX_MAX = 32'h7FFF_FFFF;
	localparam logic [FIELD_BITS-1:0] FX_MIN = 32'h8000_0000;
	localparam logic [3:0] ACTION_MAX = 4'hF;

	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_PCT = 30;
	localparam int STEADY_LO = 250;
	localparam int STEADY_HI = 400;
	localparam int HOLD_AT = 100;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 30000;
	localparam int REPORT_MAX = 40;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	fpa_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	fpa_rsp_t rsp;

	fpa_req_t pending_req[$];
	fpa_rsp_t expected_rsp[$];
	logic     req_took = 1'b0;
	int       sent_count = 0;
	int       rcvd_count = 0;
	int       item_total = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;

	fixed_point_alu_top #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Clamp to the word range, raising the overflow flag when clipped
	function automatic longint saturate(longint v, ref bit ovf);
		if (v > WORD_MAX) begin
			ovf = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			ovf = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// Exact fixed-point result and flags for one request beat
	function automatic fpa_rsp_t alu_predict(fpa_req_t r);
		longint a, b, v, prod;
		longint unsigned mag, num, den, q;
		bit neg, ovf, dz;
		fpa_rsp_t p;
		a = longint'($signed(r.operand_a));
		b = longint'($signed(r.operand_b));
		a = (a <<< (64 - IN_BITS)) >>> (64 - IN_BITS);
		b = (b <<< (64 - IN_BITS)) >>> (64 - IN_BITS);
		ovf = 1'b0;
		dz = 1'b0;
		v = 0;
		case (r.action)
			OP_ADD: v = saturate(a + b, ovf);
			OP_SUB: v = saturate(a - b, ovf);
			OP_MUL: begin
				prod = a * b;
				neg = prod < 0;
				mag = neg ? -prod : prod;
				q = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
				v = saturate(neg ? -longint'(q) : longint'(q), ovf);
			end
			OP_DIV: begin
				if (b == 0) begin
					dz = 1'b1;
					v = (a >= 0) ? WORD_MAX : WORD_MIN;
				end else begin
					neg = (a < 0) != (b < 0);
					num = longint'(a < 0 ? -a : a) << FRAC_BITS;
					den = (b < 0) ? -b : b;
					q = (2 * num + den) / (2 * den);
					v = saturate(neg ? -longint'(q) : longint'(q), ovf);
				end
			end
			OP_MIN: v = (a < b) ? a : b;
			OP_MAX: v = (a > b) ? a : b;
			OP_INC: v = saturate(a + 1, ovf);
			OP_DEC: v = saturate(a - 1, ovf);
			OP_FROM_INT: v = saturate(a * (longint'(1) <<< FRAC_BITS), ovf);
			OP_TO_INT: v = a >>> FRAC_BITS;
			default: v = 0;
		endcase
		p.result = v[FIELD_BITS-1:0];
		p.a_less_b = a < b;
		p.a_equal_b = a == b;
		p.a_greater_b = a > b;
		p.overflow = ovf;
		p.div_by_zero = dz;
		return p;
	endfunction

	// Random operand: full range, small, near the limits, mid range or zero
	function automatic logic [FIELD_BITS-1:0] pick_operand();
		logic [FIELD_BITS-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5, 6: v = $urandom_range(0, 8191) - 4096;
			7: begin
				case ($urandom_range(0, 4))
					0: v = FX_MAX;
					1: v = FX_MIN;
					2: v = '0;
					3: v = 1;
					default: v = '1;
				endcase
			end
			8: v = $signed(v) >>> $urandom_range(8, 28);
			default: v = '0;
		endcase
		return v;
	endfunction

	task automatic queue_req(logic [3:0] act, logic [FIELD_BITS-1:0] a, logic [FIELD_BITS-1:0] b);
		fpa_req_t it;
		it.action = act;
		it.operand_a = a;
		it.operand_b = b;
		pending_req.push_back(it);
	endtask

	task automatic check_field(string name, logic [FIELD_BITS-1:0] want, logic [FIELD_BITS-1:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_MAX)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Offer queued request beats; advance once a beat is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_took) begin
				if (pending_req.size() != 0 &&
				    !((sent_count < STEADY_LO || sent_count >= STEADY_HI) &&
				      $urandom_range(0, 99) < IDLE_PCT)) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Stall responses at random, with one long hold-off to back up the pipeline
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (!hold_done && rcvd_count >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (rcvd_count >= STEADY_LO && rcvd_count < STEADY_HI) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Predict each accepted request beat and check each response beat in order
	always @(posedge clk) begin
		fpa_rsp_t want;
		if (arst_n) begin
			req_took <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				expected_rsp.push_back(alu_predict(req));
				sent_count++;
			end
			if (rsp_valid && !rsp_stall) begin
				rcvd_count++;
				if (expected_rsp.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: response expected none got %h", $time, rsp);
					mismatches++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("result", want.result, rsp.result);
					check_field("a_less_b", FIELD_BITS'(want.a_less_b),
					            FIELD_BITS'(rsp.a_less_b));
					check_field("a_equal_b", FIELD_BITS'(want.a_equal_b),
					            FIELD_BITS'(rsp.a_equal_b));
					check_field("a_greater_b", FIELD_BITS'(want.a_greater_b),
					            FIELD_BITS'(rsp.a_greater_b));
					check_field("overflow", FIELD_BITS'(want.overflow),
					            FIELD_BITS'(rsp.overflow));
					check_field("div_by_zero", FIELD_BITS'(want.div_by_zero),
					            FIELD_BITS'(rsp.div_by_zero));
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [3:0] act;
		// Saturation for add, subtract and multiply, at both limits for add and subtract
		queue_req(OP_ADD, FX_MAX, FX_MAX);
		queue_req(OP_ADD, FX_MIN, FX_MIN);
		queue_req(OP_SUB, '0, FX_MIN);
		queue_req(OP_SUB, FX_MIN, 32'd1);
		queue_req(OP_MUL, FX_MAX, FX_MAX);
		queue_req(OP_MUL, FX_MIN, FX_MIN);
		// Rounding half away from zero
		queue_req(OP_MUL, 32'd1, 32'h80);
		queue_req(OP_MUL, '1, 32'h80);
		queue_req(OP_DIV, 32'd1, 32'h200);
		queue_req(OP_DIV, '1, 32'h200);
		queue_req(OP_DIV, 32'h100, 32'h300);
		// Divide by zero picks the limit by the dividend's sign
		queue_req(OP_DIV, 32'd5, '0);
		queue_req(OP_DIV, -32'sd5, '0);
		queue_req(OP_DIV, '0, '0);
		queue_req(OP_DIV, FX_MIN, '1);
		queue_req(OP_MIN, 32'd7, 32'd7);
		queue_req(OP_MIN, FX_MIN, FX_MAX);
		queue_req(OP_MAX, FX_MAX, FX_MIN);
		queue_req(OP_INC, FX_MAX, '0);
		queue_req(OP_DEC, FX_MIN, '0);
		queue_req(OP_FROM_INT, 32'h0080_0000, '0);
		queue_req(OP_FROM_INT, 32'hFF80_0000, '0);
		queue_req(OP_TO_INT, '1, '0);
		queue_req(OP_TO_INT, FX_MIN, FX_MAX);
		// Unused opcode still reports the comparison flags
		queue_req(ACTION_MAX, 32'd3, -32'sd3);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 12)
				act = 4'($urandom_range(int'(ACTION_MAX), int'(OP_TO_INT) + 1));
			else
				act = 4'($urandom_range(int'(OP_TO_INT), int'(OP_ADD)));
			queue_req(act, pick_operand(), pick_operand());
		end
		item_total = pending_req.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sent_count < item_total) @(negedge clk);
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
